/* design/compass_heading_from_xy_top_macros.svh */
// assertion macros for the compass heading block and its checker
`ifndef COMPASS_HEADING_FROM_XY_TOP_MACROS_SVH
`define COMPASS_HEADING_FROM_XY_TOP_MACROS_SVH

// clocked assertion, off while reset is low
`define CHFXY_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that also holds through reset
`define CHFXY_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/chfxy_pkg.sv */
package chfxy_pkg;

  localparam int unsigned ANGLE_ITERATIONS_DEF = 16;
  localparam int unsigned TAB_LEN  = 24;
  localparam int unsigned PRESHIFT = 20;
  localparam int unsigned MAG_W    = 16;
  localparam int unsigned ABS_W    = MAG_W + 1;
  // folded magnitude < 2^16.3 after cordic gain, plus fraction and sign
  localparam int unsigned XW       = 39;
  localparam int unsigned AW       = 32;
  localparam int unsigned HW       = 15;

  localparam logic [AW-1:0] TURN_EIGHTH  = 32'h2000_0000;
  localparam logic [AW-1:0] TURN_QUARTER = 32'h4000_0000;
  localparam logic [AW-1:0] TURN_HALF    = 32'h8000_0000;
  localparam logic [HW-1:0] STEPS_PER_TURN = 15'd23040;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [AW-1:0]        z;
  } cordic_t;

  typedef struct packed {
    logic swap;    // |y| > |x|, octant angle taken from the y axis
    logic sx_neg;
    logic sy_neg;
    logic axis;    // smaller magnitude is zero
    logic diag;    // equal magnitudes
  } meta_t;

  // atan(2^-i) in binary angle units, 2^32 per turn
  function automatic logic [AW-1:0] atan_entry(input int unsigned idx);
    logic [AW-1:0] r;
    case (idx)
      0:  r = 32'h2000_0000;
      1:  r = 32'h12E4_051E;
      2:  r = 32'h09FB_385B;
      3:  r = 32'h0511_11D4;
      4:  r = 32'h028B_0D43;
      5:  r = 32'h0145_D7E1;
      6:  r = 32'h00A2_F61E;
      7:  r = 32'h0051_7C55;
      8:  r = 32'h0028_BE53;
      9:  r = 32'h0014_5F2F;
      10: r = 32'h000A_2F98;
      11: r = 32'h0005_17CC;
      12: r = 32'h0002_8BE6;
      13: r = 32'h0001_45F3;
      14: r = 32'h0000_A2FA;
      15: r = 32'h0000_517D;
      16: r = 32'h0000_28BE;
      17: r = 32'h0000_145F;
      18: r = 32'h0000_0A30;
      19: r = 32'h0000_0518;
      20: r = 32'h0000_028C;
      21: r = 32'h0000_0146;
      22: r = 32'h0000_00A3;
      23: r = 32'h0000_0051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* design/chfxy_in_if.sv */
interface chfxy_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [chfxy_pkg::MAG_W-1:0]    mag_x;
  logic signed [chfxy_pkg::MAG_W-1:0]    mag_y;

  modport source (output valid, output mag_x, output mag_y, input ready);
  modport sink   (input valid, input mag_x, input mag_y, output ready);
endinterface

/* design/chfxy_out_if.sv */
interface chfxy_out_if;
  logic                        valid;
  logic                        ready;
  logic [chfxy_pkg::HW-1:0]    heading;

  modport source (output valid, output heading, input ready);
  modport sink   (input valid, input heading, output ready);
endinterface

/* design/chfxy_fold.sv */
module chfxy_fold (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic signed [chfxy_pkg::MAG_W-1:0] mag_x_i,
  input  logic signed [chfxy_pkg::MAG_W-1:0] mag_y_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output chfxy_pkg::cordic_t                 data_o,
  output chfxy_pkg::meta_t                   meta_o
);

  localparam int unsigned AbsW = chfxy_pkg::ABS_W;
  localparam int unsigned TopPad = chfxy_pkg::XW - AbsW - chfxy_pkg::PRESHIFT;

  logic [AbsW-1:0]    ax, ay, p, q;
  chfxy_pkg::cordic_t data_d, data_q;
  chfxy_pkg::meta_t   meta_d, meta_q;
  logic               valid_q;

  always_comb begin
    ax = mag_x_i[chfxy_pkg::MAG_W-1] ? AbsW'(-$signed({mag_x_i[chfxy_pkg::MAG_W-1], mag_x_i}))
                                     : {1'b0, mag_x_i};
    ay = mag_y_i[chfxy_pkg::MAG_W-1] ? AbsW'(-$signed({mag_y_i[chfxy_pkg::MAG_W-1], mag_y_i}))
                                     : {1'b0, mag_y_i};
    meta_d.swap   = ay > ax;
    meta_d.sx_neg = mag_x_i[chfxy_pkg::MAG_W-1];
    meta_d.sy_neg = mag_y_i[chfxy_pkg::MAG_W-1];
    p = meta_d.swap ? ay : ax;
    q = meta_d.swap ? ax : ay;
    meta_d.axis = (q == '0);
    meta_d.diag = (q == p);
    data_d.x = $signed({{TopPad{1'b0}}, p, {chfxy_pkg::PRESHIFT{1'b0}}});
    data_d.y = $signed({{TopPad{1'b0}}, q, {chfxy_pkg::PRESHIFT{1'b0}}});
    data_d.z = '0;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
      meta_q <= meta_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign meta_o  = meta_q;

endmodule

/* design/chfxy_cell.sv */
module chfxy_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  chfxy_pkg::cordic_t data_i,
  input  chfxy_pkg::meta_t   meta_i,
  output logic               valid_o,
  input  logic               ready_i,
  output chfxy_pkg::cordic_t data_o,
  output chfxy_pkg::meta_t   meta_o
);

  localparam logic [chfxy_pkg::AW-1:0] Atan = chfxy_pkg::atan_entry(STAGE);

  logic signed [chfxy_pkg::XW-1:0] dx, dy;
  chfxy_pkg::cordic_t              data_d, data_q;
  chfxy_pkg::meta_t                meta_q;
  logic                            valid_q;

  // one vectoring rotation, shifts floor towards minus infinity
  always_comb begin
    dx = $signed(data_i.y) >>> STAGE;
    dy = $signed(data_i.x) >>> STAGE;
    if (!data_i.y[chfxy_pkg::XW-1]) begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + Atan;
    end else begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - Atan;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
      meta_q <= meta_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign meta_o  = meta_q;

endmodule

/* design/chfxy_scale.sv */
module chfxy_scale (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  chfxy_pkg::cordic_t          data_i,
  input  chfxy_pkg::meta_t            meta_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [chfxy_pkg::HW-1:0]    heading_o
);

  localparam int unsigned AW = chfxy_pkg::AW;
  localparam int unsigned PW = AW + chfxy_pkg::HW + 1;

  logic [AW-1:0]             oct, theta, ang_d, ang_q;
  logic [PW-1:0]             prod;
  logic [chfxy_pkg::HW-1:0]  h, heading_d, heading_q;
  logic                      va_q, vb_q, en_b;

  // octant angle to full-turn binary angle
  always_comb begin
    if (meta_i.axis) begin
      oct = '0;
    end else if (meta_i.diag) begin
      oct = chfxy_pkg::TURN_EIGHTH;
    end else begin
      oct = data_i.z;
    end
    theta = meta_i.swap ? chfxy_pkg::TURN_QUARTER - oct : oct;
    case ({meta_i.sx_neg, meta_i.sy_neg})
      2'b00:   ang_d = theta;
      2'b10:   ang_d = chfxy_pkg::TURN_HALF - theta;
      2'b11:   ang_d = chfxy_pkg::TURN_HALF + theta;
      default: ang_d = '0 - theta;
    endcase
  end

  // scale to 1/64 degree, round half up, wrap a full turn to zero
  always_comb begin
    prod = {{(PW-AW){1'b0}}, ang_q} * PW'(chfxy_pkg::STEPS_PER_TURN)
           + PW'(chfxy_pkg::TURN_HALF);
    h = prod[AW +: chfxy_pkg::HW];
    heading_d = (h >= chfxy_pkg::STEPS_PER_TURN) ? '0 : h;
  end

  assign en_b    = !vb_q || ready_i;
  assign ready_o = !va_q || en_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ready_o) begin
        va_q <= valid_i;
      end
      if (en_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ang_q <= ang_d;
    end
    if (en_b && va_q) begin
      heading_q <= heading_d;
    end
  end

  assign valid_o   = vb_q;
  assign heading_o = heading_q;

endmodule

/* design/compass_heading_from_xy_top.sv */
// channel    dir  payload                     transfer when
// sample_i   in   mag_x[15:0], mag_y[15:0]    valid & ready
// result_o   out  heading[14:0]               valid & ready
//
// one sample pair per clock while the output is not stalled
// a sample passes the octant fold register, the row of cordic cells, one rotation
// per cell, then two scaling registers (angle map, then multiply)
// reset clears only the valid bits of the stages
// each stage takes a new item when it is empty or its neighbor moves, so
// bubbles close up and input is taken while a result waits at the output
module compass_heading_from_xy_top #(
  parameter int unsigned ANGLE_ITERATIONS = chfxy_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  chfxy_in_if.sink    sample_i,
  chfxy_out_if.source result_o
);

  chfxy_pkg::cordic_t c_data  [0:ANGLE_ITERATIONS];
  chfxy_pkg::meta_t   c_meta  [0:ANGLE_ITERATIONS];
  logic               c_valid [0:ANGLE_ITERATIONS];
  logic               c_ready [0:ANGLE_ITERATIONS];

  chfxy_fold u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sample_i.valid),
    .ready_o (sample_i.ready),
    .mag_x_i (sample_i.mag_x),
    .mag_y_i (sample_i.mag_y),
    .valid_o (c_valid[0]),
    .ready_i (c_ready[0]),
    .data_o  (c_data[0]),
    .meta_o  (c_meta[0])
  );

  for (genvar k = 0; k < ANGLE_ITERATIONS; k++) begin : g_cell
    chfxy_cell #(
      .STAGE (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c_valid[k]),
      .ready_o (c_ready[k]),
      .data_i  (c_data[k]),
      .meta_i  (c_meta[k]),
      .valid_o (c_valid[k+1]),
      .ready_i (c_ready[k+1]),
      .data_o  (c_data[k+1]),
      .meta_o  (c_meta[k+1])
    );
  end

  chfxy_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (c_valid[ANGLE_ITERATIONS]),
    .ready_o   (c_ready[ANGLE_ITERATIONS]),
    .data_i    (c_data[ANGLE_ITERATIONS]),
    .meta_i    (c_meta[ANGLE_ITERATIONS]),
    .valid_o   (result_o.valid),
    .ready_i   (result_o.ready),
    .heading_o (result_o.heading)
  );

endmodule

/* design/chfxy_checker.sv */
`include "compass_heading_from_xy_top_macros.svh"

module chfxy_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [chfxy_pkg::HW-1:0]   heading_i
);

  // items taken in and not yet delivered
  logic [5:0] cnt_d, cnt_q;

  always_comb begin
    cnt_d = cnt_q + 6'(in_valid_i && in_ready_i) - 6'(out_valid_i && out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `CHFXY_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(heading_i), "result changed while stalled")
  `CHFXY_ASSERT_ALWAYS(a_range, out_valid_i |-> heading_i < chfxy_pkg::STEPS_PER_TURN, "heading out of range")
  `CHFXY_ASSERT(a_no_invent, out_valid_i |-> cnt_q != '0, "result without a pending sample")
  `CHFXY_ASSERT(a_ready_empty, !out_valid_i |-> in_ready_i, "input stalled with empty output")

endmodule

bind compass_heading_from_xy_top chfxy_checker u_chfxy_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .heading_i   (result_o.heading)
);

/* sim/tb_compass_heading_from_xy_top.sv */
`timescale 1ns / 100ps

typedef logic signed [chfxy_pkg::MAG_W-1:0] mag_t;
typedef logic [chfxy_pkg::HW-1:0] heading_t;

class heading_scoreboard;
  typedef struct {
    mag_t     x;
    mag_t     y;
    heading_t heading;
  } heading_exp_t;

  heading_exp_t heading_q[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  function logic [chfxy_pkg::AW-1:0] atan_step(int unsigned idx);
    logic [chfxy_pkg::AW-1:0] r;
    case (idx)
      0:  r = 32'h2000_0000;
      1:  r = 32'h12E4_051E;
      2:  r = 32'h09FB_385B;
      3:  r = 32'h0511_11D4;
      4:  r = 32'h028B_0D43;
      5:  r = 32'h0145_D7E1;
      6:  r = 32'h00A2_F61E;
      7:  r = 32'h0051_7C55;
      8:  r = 32'h0028_BE53;
      9:  r = 32'h0014_5F2F;
      10: r = 32'h000A_2F98;
      11: r = 32'h0005_17CC;
      12: r = 32'h0002_8BE6;
      13: r = 32'h0001_45F3;
      14: r = 32'h0000_A2FA;
      15: r = 32'h0000_517D;
      16: r = 32'h0000_28BE;
      17: r = 32'h0000_145F;
      18: r = 32'h0000_0A30;
      19: r = 32'h0000_0518;
      20: r = 32'h0000_028C;
      21: r = 32'h0000_0146;
      22: r = 32'h0000_00A3;
      23: r = 32'h0000_0051;
      default: r = '0;
    endcase
    return r;
  endfunction

  // vectoring rotation on p >= q >= 0, angle in 2^32 per turn
  function logic [chfxy_pkg::AW-1:0] octant_angle(longint p, longint q);
    longint cx, cy, cz, dx, dy;
    int unsigned n;
    if (q == 0) return '0;
    if (q == p) return chfxy_pkg::TURN_EIGHTH;
    cx = p <<< chfxy_pkg::PRESHIFT;
    cy = q <<< chfxy_pkg::PRESHIFT;
    cz = 0;
    n = (chfxy_pkg::ANGLE_ITERATIONS_DEF > chfxy_pkg::TAB_LEN) ?
        chfxy_pkg::TAB_LEN : chfxy_pkg::ANGLE_ITERATIONS_DEF;
    for (int unsigned i = 0; i < n; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx;
        cy -= dy;
        cz += longint'(atan_step(i));
      end else begin
        cx -= dx;
        cy += dy;
        cz -= longint'(atan_step(i));
      end
    end
    return cz[chfxy_pkg::AW-1:0];
  endfunction

  function heading_t compute_heading(mag_t x, mag_t y);
    longint ax, ay;
    logic [chfxy_pkg::AW-1:0] theta, ang;
    logic [63:0] scaled;
    ax = (x < 0) ? -longint'(x) : longint'(x);
    ay = (y < 0) ? -longint'(y) : longint'(y);
    if (ax == 0 && ay == 0) return '0;
    if (ay > ax) theta = chfxy_pkg::TURN_QUARTER - octant_angle(ay, ax);
    else theta = octant_angle(ax, ay);
    if (x >= 0 && y >= 0) ang = theta;
    else if (x < 0 && y >= 0) ang = chfxy_pkg::TURN_HALF - theta;
    else if (x < 0) ang = chfxy_pkg::TURN_HALF + theta;
    else ang = '0 - theta;
    scaled = (64'(ang) * 64'(chfxy_pkg::STEPS_PER_TURN) + 64'h8000_0000) >> 32;
    // a heading that rounds up to a full turn reads as north
    if (scaled >= 64'(chfxy_pkg::STEPS_PER_TURN)) scaled = '0;
    return scaled[chfxy_pkg::HW-1:0];
  endfunction

  function void note_sample(mag_t x, mag_t y);
    heading_exp_t e;
    e.x = x;
    e.y = y;
    e.heading = compute_heading(x, y);
    heading_q.push_back(e);
  endfunction

  function int pending();
    return heading_q.size();
  endfunction

  task report_mismatch(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_heading(heading_t heading);
    heading_exp_t e;
    if (heading_q.size() == 0) begin
      report_mismatch($sformatf("heading %0d with no sample outstanding", heading));
    end else begin
      e = heading_q.pop_front();
      if (heading !== e.heading)
        report_mismatch($sformatf("x=%0d y=%0d heading %0d, expected %0d",
                                  e.x, e.y, heading, e.heading));
    end
  endtask
endclass

module tb_compass_heading_from_xy_top;

  localparam int unsigned PIPE_LATENCY = chfxy_pkg::ANGLE_ITERATIONS_DEF + 3;

  logic clk_i;
  logic rst_ni;

  chfxy_in_if  sample_if ();
  chfxy_out_if result_if ();

  compass_heading_from_xy_top uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if)
  );

  heading_scoreboard heading_sb;

  bit tx_gaps_on;
  bit rx_gaps_on;
  int rx_hold_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  // entered at a falling edge, returns at the falling edge after the transfer
  task automatic drive_sample(mag_t x, mag_t y);
    while (tx_gaps_on && $urandom_range(99) < 36) begin
      sample_if.valid = 1'b0;
      @(negedge clk_i);
    end
    sample_if.valid = 1'b1;
    sample_if.mag_x = x;
    sample_if.mag_y = y;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    heading_sb.note_sample(x, y);
    @(negedge clk_i);
  endtask

  task automatic pick_sample(output mag_t x, output mag_t y);
    int m, d, pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      x = mag_t'($urandom);
      y = mag_t'($urandom);
    end else if (pick < 68) begin
      x = mag_t'(int'($urandom_range(30)) - 15);
      y = mag_t'(int'($urandom_range(30)) - 15);
    end else if (pick < 83) begin
      // near a diagonal
      m = $urandom_range(32765, 1);
      d = int'($urandom_range(4)) - 2;
      x = $urandom_range(1) ? mag_t'(m) : mag_t'(-m);
      y = $urandom_range(1) ? mag_t'(m + d) : mag_t'(-(m + d));
    end else if (pick < 93) begin
      m = mag_t'($urandom);
      if ($urandom_range(1)) begin
        x = mag_t'(m);
        y = '0;
      end else begin
        x = '0;
        y = mag_t'(m);
      end
    end else begin
      // just below the x axis, where the heading may wrap to north
      x = mag_t'($urandom_range(32767, 16000));
      y = mag_t'(-int'($urandom_range(20, 1)));
    end
  endtask

  task automatic drive_random(int count);
    mag_t x, y;
    repeat (count) begin
      pick_sample(x, y);
      drive_sample(x, y);
    end
  endtask

  task automatic wait_drained();
    while (heading_sb.pending() != 0) @(negedge clk_i);
  endtask

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    result_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_req > 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        result_if.ready = 1'b0;
        hold_left--;
      end else begin
        result_if.ready = !(rx_gaps_on && $urandom_range(99) < 36);
      end
      @(posedge clk_i);
      if (result_if.valid && result_if.ready) heading_sb.check_heading(result_if.heading);
    end
  end

  initial begin
    heading_sb = new();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    rx_hold_req = 0;
    sample_if.valid = 1'b0;
    sample_if.mag_x = '0;
    sample_if.mag_y = '0;
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // extremes, axes, diagonals and the wrap to north
    drive_sample(16'sd0, 16'sd0);
    drive_sample(16'sd1, 16'sd0);
    drive_sample(-16'sd1, 16'sd0);
    drive_sample(16'sd0, 16'sd1);
    drive_sample(16'sd0, -16'sd1);
    drive_sample(16'sd32767, 16'sd0);
    drive_sample(-16'sd32768, 16'sd0);
    drive_sample(16'sd0, 16'sd32767);
    drive_sample(16'sd0, -16'sd32768);
    drive_sample(16'sd32767, 16'sd32767);
    drive_sample(-16'sd32768, -16'sd32768);
    drive_sample(-16'sd32768, 16'sd32767);
    drive_sample(16'sd32767, -16'sd32768);
    drive_sample(16'sd100, 16'sd100);
    drive_sample(-16'sd100, 16'sd100);
    drive_sample(-16'sd100, -16'sd100);
    drive_sample(16'sd100, -16'sd100);
    drive_sample(16'sd1, 16'sd1);
    drive_sample(16'sd32767, -16'sd1);
    drive_sample(16'sd20000, -16'sd3);
    drive_sample(-16'sd32768, -16'sd1);
    drive_sample(16'sd1, 16'sd32767);

    drive_random(250);

    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    drive_random(150);

    // fill the pipeline against a held-off receiver
    rx_hold_req = 200;
    drive_random(60);

    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    sample_if.valid = 1'b0;
    wait_drained();
    drive_random(240);

    sample_if.valid = 1'b0;
    wait_drained();
    repeat (PIPE_LATENCY + 10) @(negedge clk_i);
    if (heading_sb.errors == 0 && heading_sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
